@@ rtl/blsp_pkg.sv @@
// Shared constants, types and codes of the bounded LIFO stack with peek.
`timescale 1ns / 1ps
`default_nettype none
package blsp_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;
  localparam int DATA_W = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = (DEPTH < 64) ? CAP_W'(DEPTH) : CAP_W'(64);

  // Register index taken from the word address.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/blsp_if.sv @@
// Request and result channel interfaces of the stack.
`timescale 1ns / 1ps
`default_nettype none
interface blsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] value;
  logic [6:0] position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface blsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] status;
  logic       is_empty;
  logic       is_full;

  modport source (output valid, output read_data, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input read_data, input status, input is_empty,
                  input is_full, output ready);
endinterface
`default_nettype wire

@@ rtl/blsp_ctrl.sv @@
// Controller state machine: sequences a request through the stack datapath.
`timescale 1ns / 1ps
`default_nettype none
module blsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output blsp_pkg::cmd_t     cmd
);

  blsp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blsp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    logic out_free;
    out_free      = !out_valid_r || out_ready;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      blsp_pkg::S_IDLE: begin
        // No request is taken while reset is held.
        in_ready   = rst_n;
        cmd.accept = in_valid && rst_n;
        if (in_valid && rst_n) begin
          state_nxt = blsp_pkg::S_EXEC;
        end
      end
      blsp_pkg::S_EXEC: begin
        // The result leaves for the output register once it is free.
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = blsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = blsp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/blsp_dpath.sv @@
// Stack datapath: entry memory, entry count, result registers.
`timescale 1ns / 1ps
`default_nettype none
module blsp_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire blsp_pkg::cmd_t               cmd,
  input  wire logic [1:0]                   op,
  input  wire logic [blsp_pkg::DATA_W-1:0]  value,
  input  wire logic [6:0]                   position,
  input  wire logic [blsp_pkg::CAP_W-1:0]   capacity,
  output logic      [blsp_pkg::DATA_W-1:0]  read_data,
  output logic      [1:0]                   status,
  output logic                              is_empty,
  output logic                              is_full
);

  logic [blsp_pkg::DATA_W-1:0] mem [blsp_pkg::DEPTH];
  logic [blsp_pkg::DATA_W-1:0] mem_rdata_r;

  logic [blsp_pkg::CNT_W-1:0]  count_r, count_nxt;

  // Per-request results carried from the access cycle to the output load.
  logic                        rd_use_r;
  blsp_pkg::status_t           status_r;
  logic                        empty_r, full_r;

  logic [blsp_pkg::DATA_W-1:0] read_data_r;
  logic [1:0]                  status_out_r;
  logic                        is_empty_r, is_full_r;

  logic [blsp_pkg::CNT_W-1:0]  cap_eff;
  logic                        we, re, rd_use;
  logic [blsp_pkg::ADDR_W-1:0] waddr, raddr;
  logic [blsp_pkg::CNT_W-1:0]  peek_idx;
  blsp_pkg::status_t           status_c;

  always_comb begin
    logic [blsp_pkg::CNT_W-1:0] cap_ext;
    cap_ext = blsp_pkg::CNT_W'(capacity);
    cap_eff = (cap_ext > blsp_pkg::DEPTH_CNT) ? blsp_pkg::DEPTH_CNT : cap_ext;
  end

  always_comb begin
    count_nxt = count_r;
    we        = 1'b0;
    re        = 1'b0;
    rd_use    = 1'b0;
    status_c  = blsp_pkg::ST_OK;
    peek_idx  = count_r - blsp_pkg::CNT_W'(position);
    waddr     = count_r[blsp_pkg::ADDR_W-1:0];
    raddr     = peek_idx[blsp_pkg::ADDR_W-1:0];
    case (blsp_pkg::op_t'(op))
      blsp_pkg::OP_PUSH: begin
        if (count_r >= cap_eff) begin
          status_c = blsp_pkg::ST_OVERFLOW;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      blsp_pkg::OP_POP: begin
        if (count_r == '0) begin
          status_c = blsp_pkg::ST_UNDERFLOW;
        end else begin
          re        = 1'b1;
          rd_use    = 1'b1;
          count_nxt = count_r - 1'b1;
          raddr     = count_nxt[blsp_pkg::ADDR_W-1:0];
        end
      end
      blsp_pkg::OP_PEEK: begin
        if (position == '0 || blsp_pkg::CNT_W'(position) > count_r) begin
          status_c = blsp_pkg::ST_BADPOS;
        end else begin
          re     = 1'b1;
          rd_use = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept && we) begin
      mem[waddr] <= value;
    end
    if (cmd.accept && re) begin
      mem_rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_use_r <= rd_use;
      status_r <= status_c;
      empty_r  <= (count_nxt == '0);
      full_r   <= (count_nxt >= cap_eff);
    end
    if (cmd.load_out) begin
      read_data_r  <= rd_use_r ? mem_rdata_r : '0;
      status_out_r <= status_r;
      is_empty_r   <= empty_r;
      is_full_r    <= full_r;
    end
  end

  assign read_data = read_data_r;
  assign status    = status_out_r;
  assign is_empty  = is_empty_r;
  assign is_full   = is_full_r;

endmodule
`default_nettype wire

@@ rtl/bounded_lifo_stack_with_peek.sv @@
// Top level of the bounded LIFO stack of bytes with peek at a depth.
//
// Requests arrive on in_ch (op, value, position) and each yields exactly one
// result on out_ch (read_data, status, is_empty, is_full); both channels use
// a valid/ready handshake and a request moves when valid and ready are high.
// A request moves as follows: the accepting edge updates the entry count,
// writes a pushed byte and reads the entry memory through its single
// registered read port; then, once the output register is free, the
// result is loaded into it. in_ch.ready stays low until that load, so a
// new request is taken only after the last one reached the output register.
// The output register lets the next request be accepted while the previous
// result still waits; if the receiver keeps stalling, that second request
// holds in the datapath and in_ch.ready stays low until the output frees.
// The capacity register sits at byte address 0 of the APB-style port; the
// user must write it only while the block is idle; the block does not
// enforce it. Values above the built depth act as the depth. Synchronous
// reset empties the stack, drops any pending result and sets capacity to
// 64; the entry memory is not cleared, as only pushed entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module bounded_lifo_stack_with_peek (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  blsp_in_if.sink                           in_ch,
  blsp_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [blsp_pkg::APB_AW-1:0]  paddr,
  input  wire logic [blsp_pkg::APB_DW-1:0]  pwdata,
  output logic      [blsp_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  blsp_pkg::cmd_t              cmd;
  logic [blsp_pkg::CAP_W-1:0]  capacity_r;
  logic                        reg_sel;

  // Word index of the register: the address bit above the byte offset.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  // Capacity register: written in the access phase of an APB write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= blsp_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == blsp_pkg::REG_CAPACITY) begin
      capacity_r <= pwdata[blsp_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == blsp_pkg::REG_CAPACITY) begin
      prdata = blsp_pkg::APB_DW'(capacity_r);
    end
  end

  // The controller decides when a request is taken and when its result
  // moves into the output register.
  blsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath holds the entries, the count and the result registers.
  blsp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .op        (in_ch.op),
    .value     (in_ch.value),
    .position  (in_ch.position),
    .capacity  (capacity_r),
    .read_data (out_ch.read_data),
    .status    (out_ch.status),
    .is_empty  (out_ch.is_empty),
    .is_full   (out_ch.is_full)
  );

endmodule
`default_nettype wire

@@ tb/sv/bounded_lifo_stack_with_peek_test.sv @@
// Self-checking testbench for the bounded LIFO stack of bytes with peek at a depth.
`timescale 1ns / 1ps
module bounded_lifo_stack_with_peek_test;
  import blsp_pkg::*;

  // The run is stopped here if the handshakes ever lock up.
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_LIMIT = 50;
  localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * int'(REG_CAPACITY));

  // One request as it is offered on the input channel.
  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic [6:0] position;
  } stack_req_t;

  // One result as it leaves the output channel.
  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
    logic       is_empty;
    logic       is_full;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  blsp_in_if in_bus ();
  blsp_out_if out_bus ();

  bounded_lifo_stack_with_peek dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own image of the stack, advanced once for every accepted request.
  logic [7:0] stack_image [DEPTH];
  int unsigned depth_used = 0;
  logic [CAP_W-1:0] capacity_setting = CAP_RESET;

  // Requests waiting to be offered, and results still owed by the block.
  stack_req_t pending_requests [$];
  stack_result_t expected_results [$];

  // Running count kept while requests are generated, so that most peeks can
  // be aimed at a depth that actually holds an entry.
  int gen_count = 0;
  int gen_capacity = DEPTH;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit in_accepted = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // All inputs of the block hold known values from the very start.
  initial begin
    in_bus.valid = 1'b0;
    in_bus.op = OP_NOP;
    in_bus.value = '0;
    in_bus.position = '0;
    out_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
  end

  // Works out the result of one request and moves the stack image on. A push
  // is refused once the count has reached the effective capacity, which is
  // the capacity register saturated at the built depth. A lowered capacity
  // keeps the entries that are already held.
  function automatic stack_result_t apply_request(stack_req_t req);
    stack_result_t res;
    int unsigned eff_cap;
    eff_cap = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
    res.read_data = '0;
    res.status = ST_OK;
    case (req.op)
      OP_PUSH: begin
        if (depth_used >= eff_cap) begin
          res.status = ST_OVERFLOW;
        end else begin
          stack_image[depth_used] = req.value;
          depth_used++;
        end
      end
      OP_POP: begin
        if (depth_used == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          depth_used--;
          res.read_data = stack_image[depth_used];
        end
      end
      OP_PEEK: begin
        // Depth one is the top; depth zero and depths past the count are refused.
        if (req.position == 0 || req.position > depth_used) begin
          res.status = ST_BADPOS;
        end else begin
          res.read_data = stack_image[depth_used - req.position];
        end
      end
      default: ;
    endcase
    res.is_empty = (depth_used == 0);
    res.is_full = (depth_used >= eff_cap);
    return res;
  endfunction

  function automatic stack_req_t make_req(op_t op, logic [7:0] value, logic [6:0] position);
    stack_req_t req;
    req.op = op;
    req.value = value;
    req.position = position;
    return req;
  endfunction

  task automatic add_item(stack_req_t req);
    pending_requests.push_back(req);
    if (req.op == OP_PUSH && gen_count < gen_capacity) begin
      gen_count++;
    end else if (req.op == OP_POP && gen_count > 0) begin
      gen_count--;
    end
  endtask

  // A random request; push_weight is the percentage of pushes, which steers
  // the stack towards full or towards empty. While entries are held, three
  // peeks in four go to a depth that holds one, the rest to any depth 0 to DEPTH.
  task automatic add_random(int push_weight);
    stack_req_t req;
    int pick;
    pick = $urandom_range(99);
    req.value = 8'($urandom_range(255));
    req.position = 7'($urandom_range(DEPTH));
    if (pick < push_weight) begin
      req.op = OP_PUSH;
    end else if (pick >= 97) begin
      req.op = OP_NOP;
    end else if ($urandom_range(1) == 1) begin
      req.op = OP_POP;
    end else begin
      req.op = OP_PEEK;
      if (gen_count > 0 && $urandom_range(3) != 0) begin
        req.position = 7'($urandom_range(gen_count, 1));
      end
    end
    add_item(req);
  endtask

  // Waits until every queued request has been taken and every result has
  // come back; a short pause follows so that the block is idle afterwards.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_bus.valid === 1'b1
           || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  // One APB write to the capacity register: a setup phase, then an access
  // phase that completes at the edge where pready is seen high. The register
  // is read back afterwards.
  task automatic set_capacity(int cap);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= APB_DW'(cap);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    capacity_setting = CAP_W'(cap);
    gen_capacity = ((cap & 127) > DEPTH) ? DEPTH : (cap & 127);
    @(negedge clk);
    if (prdata !== APB_DW'(capacity_setting)) begin
      error_count++;
      $display("%0t: capacity read back: expected %0d, actual %0d",
               $time, capacity_setting, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A random phase: first half leaning one way, then the sender holds off
  // until every outstanding result is back, then the second half.
  task automatic run_phase(int cap, int send_pct, int stall_pct, int n,
                           int push_first, int push_second);
    set_capacity(cap);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        wait_drained();
      end
      add_random((i < n / 2) ? push_first : push_second);
    end
    wait_drained();
  endtask

  // Request driver. A new request is offered at the falling edge once the
  // previous one has been taken; the sender may idle at random instead. The
  // receiver's ready is redrawn every cycle.
  always @(negedge clk) begin
    stack_req_t next_req;
    if (!in_bus.valid || in_accepted) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.op <= next_req.op;
        in_bus.value <= next_req.value;
        in_bus.position <= next_req.position;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor and checker. An accepted request adds its predicted result to
  // the back of the queue; an accepted result is compared with the front.
  // A result taken at the same edge as a request always belongs to an older
  // request, so the order of the two steps below does not matter.
  always @(posedge clk) begin
    stack_req_t seen_req;
    stack_result_t got;
    stack_result_t want;
    in_accepted = rst_n && in_bus.valid && in_bus.ready;
    if (in_accepted) begin
      seen_req.op = op_t'(in_bus.op);
      seen_req.value = in_bus.value;
      seen_req.position = in_bus.position;
      expected_results.push_back(apply_request(seen_req));
    end
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.read_data = out_bus.read_data;
      got.status = status_t'(out_bus.status);
      got.is_empty = out_bus.is_empty;
      got.is_full = out_bus.is_full;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: result with no request outstanding: read_data=%h status=%0d",
                   $time, got.read_data, got.status);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.read_data !== want.read_data || got.status !== want.status
            || got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch: expected read_data=%h status=%0d empty=%b full=%b",
                     $time, want.read_data, want.status, want.is_empty, want.is_full);
            $display("%0t:           actual read_data=%h status=%0d empty=%b full=%b",
                     $time, got.read_data, got.status, got.is_empty, got.is_full);
          end
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at the reset capacity: pop and peeks on an empty
    // stack, an idle op code, the extreme bytes, peeks at the top, at the
    // bottom, just below the bottom, at depth zero and at the largest depth.
    add_item(make_req(OP_POP, 8'h00, 7'd0));
    add_item(make_req(OP_PEEK, 8'h00, 7'd0));
    add_item(make_req(OP_PEEK, 8'hFF, 7'd1));
    add_item(make_req(OP_NOP, 8'hFF, 7'h7F));
    add_item(make_req(OP_PUSH, 8'h00, 7'd0));
    add_item(make_req(OP_PUSH, 8'hFF, 7'h7F));
    add_item(make_req(OP_PUSH, 8'h5A, 7'd0));
    add_item(make_req(OP_PEEK, 8'h00, 7'd1));
    add_item(make_req(OP_PEEK, 8'h00, 7'd3));
    add_item(make_req(OP_PEEK, 8'h00, 7'd4));
    add_item(make_req(OP_PEEK, 8'h00, 7'd0));
    add_item(make_req(OP_POP, 8'h00, 7'd0));
    add_item(make_req(OP_PEEK, 8'h00, 7'd64));
    wait_drained();

    // Capacity lowered below the two entries held: full straight away, the
    // push is refused, and pops still return what was stored.
    set_capacity(1);
    add_item(make_req(OP_PUSH, 8'h11, 7'd0));
    add_item(make_req(OP_POP, 8'h00, 7'd0));
    add_item(make_req(OP_POP, 8'h00, 7'd0));
    add_item(make_req(OP_POP, 8'h00, 7'd0));
    add_item(make_req(OP_PUSH, 8'h3C, 7'd0));
    add_item(make_req(OP_PUSH, 8'hC3, 7'd0));
    wait_drained();

    // Capacity zero: every push overflows and full always reads high.
    set_capacity(0);
    add_item(make_req(OP_PUSH, 8'h81, 7'd0));
    add_item(make_req(OP_PEEK, 8'h00, 7'd1));
    add_item(make_req(OP_POP, 8'h00, 7'd0));
    wait_drained();

    // Capacity above the built depth behaves as the depth.
    set_capacity(127);
    add_item(make_req(OP_PUSH, 8'h7E, 7'd0));
    add_item(make_req(OP_PEEK, 8'h00, 7'd2));
    wait_drained();

    // Random phases. State carries over from one phase to the next, so the
    // third phase leaves the stack deep and the fourth lowers the capacity
    // beneath the entries held.
    run_phase(64, 0, 0, 260, 60, 25);
    run_phase(1, 80, 0, 120, 55, 30);
    run_phase(127, 0, 80, 300, 65, 45);
    run_phase(5, 6, 6, 150, 50, 20);
    run_phase(0, 6, 6, 80, 50, 30);
    run_phase($urandom_range(DEPTH, 1), 6, 6, 250, 55, 25);
    run_phase(DEPTH, 0, 0, 230, 60, 25);

    // wait_drained has already let the block settle after the last result.
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
